FILE: src/sdss_pkg.sv
// ----------------------------------------------------------------------------
// sdss_pkg
// Shared widths, constants, types and the segment table of the digit scanner.
// ----------------------------------------------------------------------------
package sdss_pkg;

	localparam int unsigned DIGIT_COUNT = 6;

	localparam int unsigned VALUE_W = 20;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int unsigned CNT_W   = $clog2(DIGIT_COUNT + 1);

	localparam int unsigned DISPLAY_MAX = 10 ** DIGIT_COUNT - 1;

	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned RECIP_W     = 20;
	localparam int unsigned RECIP       = (2 ** RECIP_SHIFT + 9) / 10;
	localparam int unsigned PROD_W      = VALUE_W + RECIP_W;

	localparam logic [BYTE_W-1:0] REG_OUT_PORT0  = 8'h02;
	localparam logic [BYTE_W-1:0] BLANK_SELECT   = 8'hFF;
	localparam logic [BYTE_W-1:0] BLANK_SEGMENTS = 8'h00;
	localparam logic [BYTE_W-1:0] SELECT_MSB     = 8'h80;

	typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_t;

	typedef struct packed {
		logic    valid;
		digits_t digits;
	} dig_item_t;

	function automatic logic [BYTE_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [BYTE_W-1:0] p;
		case (d)
			4'd0: p = 8'hFC;
			4'd1: p = 8'h60;
			4'd2: p = 8'hDA;
			4'd3: p = 8'hF2;
			4'd4: p = 8'h66;
			4'd5: p = 8'hB6;
			4'd6: p = 8'h3E;
			4'd7: p = 8'hE0;
			4'd8: p = 8'hFE;
			4'd9: p = 8'hF6;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

FILE: src/sdss_front.sv
// ----------------------------------------------------------------------------
// sdss_front
// Accepts a value, clamps it and splits it into decimal digits, one per cycle.
// ----------------------------------------------------------------------------
module sdss_front
	import sdss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] value,
	output dig_item_t          push,
	input  logic               push_ready
);

	logic               busy_q;
	logic [CNT_W-1:0]   step_q;
	logic [VALUE_W-1:0] work_q;
	digits_t            dig_q;

	logic [VALUE_W-1:0] clamped;
	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] rem;
	logic               done;

	assign clamped = (32'(value) > DISPLAY_MAX) ? VALUE_W'(DISPLAY_MAX) : value;
	assign prod    = PROD_W'(work_q) * PROD_W'(RECIP);
	assign quot    = VALUE_W'(prod >> RECIP_SHIFT);
	assign rem     = work_q - (quot << 3) - (quot << 1);
	assign done    = busy_q && (step_q == CNT_W'(DIGIT_COUNT));

	assign s_tready     = !busy_q;
	assign push.valid   = done;
	assign push.digits  = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (s_tvalid && !busy_q) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (done) begin
			if (push_ready) begin
				busy_q <= 1'b0;
			end
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && !busy_q) begin
			work_q <= clamped;
		end else if (busy_q && !done) begin
			// shift in least significant digit first; most significant ends at 0
			work_q <= quot;
			for (int k = DIGIT_COUNT - 1; k > 0; k--) begin
				dig_q[k] <= dig_q[k-1];
			end
			dig_q[0] <= rem[DIGIT_W-1:0];
		end
	end

endmodule

FILE: src/sdss_queue.sv
// ----------------------------------------------------------------------------
// sdss_queue
// Two-entry queue of digit sets between the front and back parts.
// ----------------------------------------------------------------------------
module sdss_queue
	import sdss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dig_item_t push,
	output logic      push_ready,
	output dig_item_t head,
	input  logic      pop
);

	digits_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_push;
	logic do_pop;

	assign push_ready  = (count_q != 2'd2);
	assign head.valid  = (count_q != 2'd0);
	assign head.digits = mem_q[rd_ptr_q];
	assign do_push     = push.valid && push_ready;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.digits;
		end
	end

endmodule

FILE: src/sdss_back.sv
// ----------------------------------------------------------------------------
// sdss_back
// Emits a digit write and a blanking write for each digit of a queued set.
// ----------------------------------------------------------------------------
module sdss_back
	import sdss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dig_item_t         head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] register_index,
	output logic [BYTE_W-1:0] digit_select,
	output logic [BYTE_W-1:0] segments,
	output logic              is_blank,
	output logic              last
);

	logic             loaded_q;
	digits_t          digits_q;
	logic [IDX_W-1:0] digit_q;
	logic             blank_q;

	logic take;

	assign m_tvalid       = loaded_q;
	assign take           = loaded_q && m_tready;
	assign last           = blank_q && (digit_q == IDX_W'(DIGIT_COUNT - 1));
	assign is_blank       = blank_q;
	assign register_index = REG_OUT_PORT0;
	assign digit_select   = blank_q ? BLANK_SELECT : ~(SELECT_MSB >> digit_q);
	assign segments       = blank_q ? BLANK_SEGMENTS : seg_pattern(digits_q[digit_q]);
	assign pop            = !loaded_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			digit_q  <= '0;
			blank_q  <= 1'b0;
		end else if (pop) begin
			loaded_q <= head.valid;
			digit_q  <= '0;
			blank_q  <= 1'b0;
		end else if (take) begin
			if (blank_q) begin
				digit_q <= digit_q + 1'b1;
			end
			blank_q <= !blank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.valid) begin
			digits_q <= head.digits;
		end
	end

endmodule

FILE: src/six_digit_seven_segment_scan.sv
// ----------------------------------------------------------------------------
// six_digit_seven_segment_scan
// Turns a number into the port-expander writes that scan a six-digit display.
// ----------------------------------------------------------------------------
// Each accepted value (clamped to 999999) gives twelve result items, most
// significant digit first: a digit write then a blanking write per digit, the
// last one flagged by tlast. The result port moves one item per cycle while
// m_tready is high, so a steady stream of values runs at one value per twelve
// items. The front splits a value with a shared divide-by-ten unit, one digit
// per cycle, and a two-entry queue lets it work ahead of the result port.
module six_digit_seven_segment_scan
	import sdss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [19:0] value, [23:20] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] register_index, [15:8] digit_select, [23:16] segments
	output logic [0:0]  m_tuser,  // [0] is_blank
	output logic        m_tlast
);

	dig_item_t         push;
	dig_item_t         head;
	logic              push_ready;
	logic              pop;
	logic [BYTE_W-1:0] register_index;
	logic [BYTE_W-1:0] digit_select;
	logic [BYTE_W-1:0] segments;
	logic              is_blank;

	sdss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.value      (s_tdata[VALUE_W-1:0]),
		.push       (push),
		.push_ready (push_ready)
	);

	sdss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	sdss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.register_index (register_index),
		.digit_select   (digit_select),
		.segments       (segments),
		.is_blank       (is_blank),
		.last           (m_tlast)
	);

	assign m_tdata    = {segments, digit_select, register_index};
	assign m_tuser[0] = is_blank;

endmodule

FILE: sim/sdss_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdss_scan_checker
// Watches both streams of the digit scanner and checks every expander write.
// ----------------------------------------------------------------------------
// Each value taken on the input stream is clamped and split into decimal
// digits. This gives twelve expected writes: a digit write, then a blanking
// write, for each digit. Each write on the output stream is checked field by
// field against the oldest expected write. Once finished is raised, any write
// still expected counts as a failure.
module sdss_scan_checker
	import sdss_pkg::*;
(
	input  logic        clk,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // [19:0] value, [23:20] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // [7:0] register_index, [15:8] digit_select, [23:16] segments
	input  logic [0:0]  m_tuser,  // [0] is_blank
	input  logic        m_tlast,
	input  logic        finished,
	output int          fail_count,
	output int          writes_outstanding
);

	typedef struct packed {
		logic [BYTE_W-1:0] reg_index;
		logic [BYTE_W-1:0] select;
		logic [BYTE_W-1:0] segs;
		logic              blank;
		logic              last;
	} expander_write_t;

	// digit 9 in the top byte down to digit 0 in the bottom byte
	localparam logic [10*BYTE_W-1:0] DIGIT_GLYPHS = {
		8'hF6, 8'hFE, 8'hE0, 8'h3E, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
	};

	expander_write_t expected_writes[$];
	int              errors = 0;
	logic            leftovers_checked = 1'b0;

	function automatic void queue_display_writes(input logic [VALUE_W-1:0] value);
		int unsigned     shown;
		int unsigned     digit [DIGIT_COUNT];
		expander_write_t w;
		shown = value;
		if (shown > DISPLAY_MAX)
			shown = DISPLAY_MAX;
		for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
			digit[i] = shown % 10;
			shown = shown / 10;
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			w.reg_index = REG_OUT_PORT0;
			w.select    = ~(SELECT_MSB >> i);
			w.segs      = DIGIT_GLYPHS[digit[i]*BYTE_W +: BYTE_W];
			w.blank     = 1'b0;
			w.last      = 1'b0;
			expected_writes.push_back(w);
			w.select    = BLANK_SELECT;
			w.segs      = BLANK_SEGMENTS;
			w.blank     = 1'b1;
			w.last      = (i == DIGIT_COUNT - 1);
			expected_writes.push_back(w);
		end
	endfunction

	function automatic int field_differs(input string what, input logic [BYTE_W-1:0] want_v,
			input logic [BYTE_W-1:0] got_v);
		if (want_v === got_v)
			return 0;
		$display("%0t ns: %s expected %02h actual %02h", $time, what, want_v, got_v);
		return 1;
	endfunction

	always @(posedge clk) begin
		expander_write_t got;
		expander_write_t want;
		if (s_tvalid && s_tready)
			queue_display_writes(s_tdata[VALUE_W-1:0]);
		if (m_tvalid && m_tready) begin
			got.reg_index = m_tdata[7:0];
			got.select    = m_tdata[15:8];
			got.segs      = m_tdata[23:16];
			got.blank     = m_tuser[0];
			got.last      = m_tlast;
			if (expected_writes.size() == 0) begin
				$display("%0t ns: write with none expected, expected none actual %h",
					$time, got);
				errors++;
			end else begin
				want = expected_writes.pop_front();
				errors += field_differs("register_index", want.reg_index, got.reg_index);
				errors += field_differs("digit_select", want.select, got.select);
				errors += field_differs("segments", want.segs, got.segs);
				errors += field_differs("is_blank", BYTE_W'(want.blank), BYTE_W'(got.blank));
				errors += field_differs("last", BYTE_W'(want.last), BYTE_W'(got.last));
			end
		end
		if (finished && !leftovers_checked) begin
			leftovers_checked <= 1'b1;
			if (expected_writes.size() != 0) begin
				$display("%0t ns: %0d writes expected, actual 0 arrived", $time,
					expected_writes.size());
				errors += expected_writes.size();
			end
		end
		writes_outstanding <= expected_writes.size();
		fail_count <= errors;
	end

endmodule

FILE: sim/tb_six_digit_seven_segment_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_digit_seven_segment_scan
// Stimulus and verdict for the six-digit seven-segment scanner.
// ----------------------------------------------------------------------------
// The stimulus opens with corner values: zero, leading zeros, powers of ten,
// the display maximum and the saturating values up to all ones. Random values
// follow, weighted toward small, near-limit and saturating numbers. Both
// streams idle at random, in stretches of wide, short and no gaps. The
// receiver once holds off for a long time so that the input stalls. The
// sender waits three times for all writes to drain. Checking is left to
// sdss_scan_checker.
module tb_six_digit_seven_segment_scan
	import sdss_pkg::*;
();

	localparam int RANDOM_VALUES = 260;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AT_WRITE = 600;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int WAIT_MAX      = 17;

	typedef enum int {IDLE_WIDE, IDLE_NONE, IDLE_SHORT} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        finished;
	int          fail_count;
	int          writes_outstanding;
	int          cycle_count = 0;
	int          writes_taken = 0;

	six_digit_seven_segment_scan DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sdss_scan_checker u_checker (
		.clk                (clk),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tuser            (m_tuser),
		.m_tlast            (m_tlast),
		.finished           (finished),
		.fail_count         (fail_count),
		.writes_outstanding (writes_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int draw_wait(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_SHORT: return $urandom_range(0, 3);
			default:    return $urandom_range(0, WAIT_MAX);
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0:       return VALUE_W'($urandom_range(0, 999));
			1:       return VALUE_W'($urandom_range(DISPLAY_MAX - 10, DISPLAY_MAX + 10));
			2:       return VALUE_W'($urandom_range(DISPLAY_MAX + 1, 2 ** VALUE_W - 1));
			default: return VALUE_W'($urandom_range(0, 2 ** VALUE_W - 1));
		endcase
	endfunction

	task automatic send_value(input logic [VALUE_W-1:0] value, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (writes_outstanding != 0) @(posedge clk);
	endtask

	// receiver: random readiness, one long hold-off
	initial begin
		idle_mode_t rx_mode;
		int         w;
		rx_mode = IDLE_WIDE;
		@(posedge arst_n);
		forever begin
			if (writes_taken % 30 == 0)
				rx_mode = idle_mode_t'($urandom_range(0, 2));
			w = draw_wait(rx_mode);
			if (writes_taken == HOLD_AT_WRITE)
				w = HOLD_CYCLES;
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			writes_taken++;
		end
	end

	initial begin
		logic [VALUE_W-1:0] corner_values [20];
		idle_mode_t         tx_mode;
		corner_values = '{
			20'd0, 20'd1, 20'd9, 20'd10, 20'd42, 20'd99, 20'd1000, 20'd10000,
			20'd100000, 20'd123456, 20'd654321, 20'd987654, 20'd999998, 20'd999999,
			20'd1000000, 20'd1000001, 20'hFFFFF, 20'h80000, 20'h55555, 20'hAAAAA
		};
		tx_mode  = IDLE_WIDE;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		finished = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i])
			send_value(corner_values[i], draw_wait(IDLE_SHORT));
		wait_drained();

		for (int n = 0; n < RANDOM_VALUES; n++) begin
			if (n % 20 == 0)
				tx_mode = idle_mode_t'($urandom_range(0, 2));
			if (n == RANDOM_VALUES / 2)
				wait_drained();
			send_value(random_value(), draw_wait(tx_mode));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		finished <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
